// File: hw/rtl/lsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the least-squares line fit unit.
// No dependencies; every other file of the block imports this package.
package lsf_pkg;

	localparam int LSF_MAX_POINTS  = 4096;
	localparam int LSF_SAMPLE_BITS = 16;
	localparam int LSF_OUT_W       = 48;
	localparam int LSF_FRAC        = 16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DCHK,
		ST_NEG,
		ST_DIV,
		ST_RND,
		ST_STORE,
		ST_FIN
	} lsf_state_t;

	// product terms, in the order the sequencer walks them
	typedef enum logic [2:0] {
		OP_NXX,   // n * Sxx
		OP_SXSX,  // - Sx * Sx   -> denominator
		OP_NXY,   // n * Sxy
		OP_SXSY,  // - Sx * Sy   -> slope numerator
		OP_SYXX,  // Sy * Sxx
		OP_SXXY   // - Sx * Sxy  -> intercept numerator
	} lsf_op_t;

	typedef struct packed {
		logic degenerate;
		logic saturated;
	} lsf_flags_t;

endpackage

// File: hw/rtl/lsf_alu.sv
`timescale 1ns / 1ps
// Shared add/subtract unit of the fit engine, with carry out.
// Depends on lsf_pkg.
module lsf_alu import lsf_pkg::*; #(
	parameter int WIDTH = 75
) (
	input  logic [WIDTH-1:0] opa,
	input  logic [WIDTH-1:0] opb,
	input  logic             sub,
	output logic [WIDTH:0]   sum
);

	// subtract as a + ~b + 1; carry out set means a >= b (unsigned)
	assign sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{WIDTH{1'b0}}, sub};

endmodule

// File: hw/rtl/lsf_accum.sv
`timescale 1ns / 1ps
// Point accumulators: count, sum x, sum y, sum x*x, sum x*y.
// Depends on lsf_pkg.
module lsf_accum import lsf_pkg::*; #(
	parameter int MAX_POINTS  = LSF_MAX_POINTS,
	parameter int SAMPLE_BITS = LSF_SAMPLE_BITS
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  take,
	input  logic signed [SAMPLE_BITS-1:0]                         x_sample,
	input  logic signed [SAMPLE_BITS-1:0]                         y_sample,
	input  logic                                                  last_point,
	output logic                                                  fit,
	output logic [$clog2(MAX_POINTS+1)-1:0]                       n_nx,
	output logic signed [SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]    sx_nx,
	output logic signed [SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]    sy_nx,
	output logic signed [2*SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]  sxx_nx,
	output logic signed [2*SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]  sxy_nx
);

	localparam int CW = $clog2(MAX_POINTS+1);
	localparam int SW = SAMPLE_BITS + CW;
	localparam int QW = 2*SAMPLE_BITS + CW;

	logic [CW-1:0]              count_q;
	logic signed [SW-1:0]       sx_q, sy_q;
	logic signed [QW-1:0]       sxx_q, sxy_q;
	logic signed [2*SAMPLE_BITS-1:0] xx, xy;

	assign xx = x_sample * x_sample;
	assign xy = x_sample * y_sample;

	assign n_nx   = count_q + CW'(1);
	assign sx_nx  = sx_q + {{(SW-SAMPLE_BITS){x_sample[SAMPLE_BITS-1]}}, x_sample};
	assign sy_nx  = sy_q + {{(SW-SAMPLE_BITS){y_sample[SAMPLE_BITS-1]}}, y_sample};
	assign sxx_nx = sxx_q + {{(QW-2*SAMPLE_BITS){xx[2*SAMPLE_BITS-1]}}, xx};
	assign sxy_nx = sxy_q + {{(QW-2*SAMPLE_BITS){xy[2*SAMPLE_BITS-1]}}, xy};

	// close the set on the marked point or when the point limit is hit
	assign fit = take && (last_point || (n_nx == CW'(MAX_POINTS)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			sxy_q   <= '0;
		end else if (fit) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			sxy_q   <= '0;
		end else if (take) begin
			count_q <= n_nx;
			sx_q    <= sx_nx;
			sy_q    <= sy_nx;
			sxx_q   <= sxx_nx;
			sxy_q   <= sxy_nx;
		end
	end

endmodule

// File: hw/rtl/lsf_engine.sv
`timescale 1ns / 1ps
// Fit engine: sequencer around one shared adder that runs shift-add
// products and restoring division. Depends on lsf_pkg and lsf_alu.
module lsf_engine import lsf_pkg::*; #(
	parameter int MAX_POINTS  = LSF_MAX_POINTS,
	parameter int SAMPLE_BITS = LSF_SAMPLE_BITS
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	input  logic [$clog2(MAX_POINTS+1)-1:0]                       n_in,
	input  logic signed [SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]    sx_in,
	input  logic signed [SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]    sy_in,
	input  logic signed [2*SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]  sxx_in,
	input  logic signed [2*SAMPLE_BITS+$clog2(MAX_POINTS+1)-1:0]  sxy_in,
	input  logic                                                  res_take,
	output logic                                                  busy,
	output logic                                                  res_valid,
	output logic [LSF_OUT_W-1:0]                                  res_slope,
	output logic [LSF_OUT_W-1:0]                                  res_icpt,
	output logic [$clog2(MAX_POINTS+1)-1:0]                       res_count,
	output lsf_flags_t                                            res_flags
);

	localparam int CW = $clog2(MAX_POINTS+1);
	localparam int SW = SAMPLE_BITS + CW;
	localparam int QW = 2*SAMPLE_BITS + CW;
	localparam int AW = SW + QW + 1;
	localparam int RW = CW + QW;
	localparam int NW = AW + LSF_FRAC;
	localparam int KW = $clog2(NW+1);
	localparam int OW = LSF_OUT_W;

	lsf_state_t state_q, state_d;
	lsf_op_t    op_q, op_d;
	logic [KW-1:0] cnt_q, cnt_d;

	logic [CW-1:0]        n_q;
	logic signed [SW-1:0] sx_q, sy_q;
	logic signed [QW-1:0] sxx_q, sxy_q;

	logic [AW-1:0] a_q, acc_q;
	logic [SW-1:0] b_q;
	logic          sub_q;
	logic [RW-1:0] den_q, rem_q;
	logic          neg_q, ovf_q, rnd_q, sat_q, deg_q;
	logic [NW-1:0] num_q;
	logic [OW:0]   quo_q;
	logic [OW-1:0] slope_q, icpt_q;

	logic [AW-1:0] opa, opb;
	logic          alu_sub;
	logic [AW:0]   alu_sum;

	logic [AW-1:0]        a_ld;
	logic signed [SW-1:0] b_ld;
	logic [SW-1:0]        b_mag;
	logic                 op_sub, op_clr, deg_now;

	logic [OW+1:0] qr, lim;
	logic          sat_st;
	logic [OW-1:0] mag_st, res_st;

	lsf_alu #(.WIDTH(AW)) u_alu (
		.opa (opa),
		.opb (opb),
		.sub (alu_sub),
		.sum (alu_sum)
	);

	// operand select per product term
	always_comb begin
		a_ld   = '0;
		b_ld   = '0;
		op_sub = 1'b0;
		op_clr = 1'b0;
		unique case (op_q)
			OP_NXX: begin
				a_ld   = {{(AW-QW){sxx_q[QW-1]}}, sxx_q};
				b_ld   = {{(SW-CW){1'b0}}, n_q};
				op_clr = 1'b1;
			end
			OP_SXSX: begin
				a_ld   = {{(AW-SW){sx_q[SW-1]}}, sx_q};
				b_ld   = sx_q;
				op_sub = 1'b1;
			end
			OP_NXY: begin
				a_ld   = {{(AW-QW){sxy_q[QW-1]}}, sxy_q};
				b_ld   = {{(SW-CW){1'b0}}, n_q};
				op_clr = 1'b1;
			end
			OP_SXSY: begin
				a_ld   = {{(AW-SW){sy_q[SW-1]}}, sy_q};
				b_ld   = sx_q;
				op_sub = 1'b1;
			end
			OP_SYXX: begin
				a_ld   = {{(AW-QW){sxx_q[QW-1]}}, sxx_q};
				b_ld   = sy_q;
				op_clr = 1'b1;
			end
			OP_SXXY: begin
				a_ld   = {{(AW-QW){sxy_q[QW-1]}}, sxy_q};
				b_ld   = sx_q;
				op_sub = 1'b1;
			end
			default: begin
				a_ld = '0;
			end
		endcase
		b_mag = b_ld[SW-1] ? (SW'(0) - b_ld) : b_ld;
	end

	assign deg_now = (acc_q == '0) || acc_q[AW-1];

	// shared adder operands
	always_comb begin
		opa     = acc_q;
		opb     = a_q;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_MUL: begin
				opa     = acc_q;
				opb     = a_q;
				alu_sub = sub_q;
			end
			ST_NEG: begin
				opa     = '0;
				opb     = acc_q;
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				opa     = {{(AW-RW-1){1'b0}}, rem_q, num_q[NW-1]};
				opb     = {{(AW-RW){1'b0}}, den_q};
				alu_sub = 1'b1;
			end
			ST_RND: begin
				opa     = {{(AW-RW-1){1'b0}}, rem_q, 1'b0};
				opb     = {{(AW-RW){1'b0}}, den_q};
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// round, clamp and restore sign of the quotient
	always_comb begin
		qr     = {1'b0, quo_q} + (OW+2)'(rnd_q);
		lim    = {3'b000, {(OW-1){1'b1}}} + (OW+2)'(neg_q);
		sat_st = ovf_q || (qr > lim);
		mag_st = sat_st ? lim[OW-1:0] : qr[OW-1:0];
		res_st = neg_q ? (OW'(0) - mag_st) : mag_st;
	end

	// next state
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOAD;
					op_d    = OP_NXX;
				end
			end
			ST_LOAD: begin
				state_d = ST_MUL;
				cnt_d   = '0;
			end
			ST_MUL: begin
				if (cnt_q == KW'(SW-1)) begin
					unique case (op_q)
						OP_NXX:  begin op_d = OP_SXSX; state_d = ST_LOAD; end
						OP_NXY:  begin op_d = OP_SXSY; state_d = ST_LOAD; end
						OP_SYXX: begin op_d = OP_SXXY; state_d = ST_LOAD; end
						OP_SXSX: state_d = ST_DCHK;
						OP_SXSY: state_d = ST_NEG;
						OP_SXXY: state_d = ST_NEG;
						default: state_d = ST_IDLE;
					endcase
				end else begin
					cnt_d = cnt_q + KW'(1);
				end
			end
			ST_DCHK: begin
				if (deg_now) begin
					state_d = ST_FIN;
				end else begin
					op_d    = OP_NXY;
					state_d = ST_LOAD;
				end
			end
			ST_NEG: begin
				state_d = ST_DIV;
				cnt_d   = '0;
			end
			ST_DIV: begin
				if (cnt_q == KW'(NW-1)) begin
					state_d = ST_RND;
				end else begin
					cnt_d = cnt_q + KW'(1);
				end
			end
			ST_RND: state_d = ST_STORE;
			ST_STORE: begin
				if (op_q == OP_SXSY) begin
					op_d    = OP_SYXX;
					state_d = ST_LOAD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NXX;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					n_q   <= n_in;
					sx_q  <= sx_in;
					sy_q  <= sy_in;
					sxx_q <= sxx_in;
					sxy_q <= sxy_in;
					sat_q <= 1'b0;
					deg_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				a_q   <= a_ld;
				b_q   <= b_mag;
				sub_q <= b_ld[SW-1] ^ op_sub;
				if (op_clr) begin
					acc_q <= '0;
				end
			end
			ST_MUL: begin
				if (b_q[0]) begin
					acc_q <= alu_sum[AW-1:0];
				end
				a_q <= {a_q[AW-2:0], 1'b0};
				b_q <= {1'b0, b_q[SW-1:1]};
			end
			ST_DCHK: begin
				den_q <= acc_q[RW-1:0];
				if (deg_now) begin
					deg_q   <= 1'b1;
					slope_q <= '0;
					icpt_q  <= '0;
				end
			end
			ST_NEG: begin
				neg_q <= acc_q[AW-1];
				num_q <= {(acc_q[AW-1] ? alu_sum[AW-1:0] : acc_q), {LSF_FRAC{1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			ST_DIV: begin
				num_q <= {num_q[NW-2:0], 1'b0};
				if (alu_sum[AW]) begin
					rem_q <= alu_sum[RW-1:0];
				end else begin
					rem_q <= {rem_q[RW-2:0], num_q[NW-1]};
				end
				quo_q <= {quo_q[OW-1:0], alu_sum[AW]};
				ovf_q <= ovf_q | quo_q[OW];
			end
			ST_RND: rnd_q <= alu_sum[AW];
			ST_STORE: begin
				if (op_q == OP_SXSY) begin
					slope_q <= res_st;
				end else begin
					icpt_q <= res_st;
				end
				sat_q <= sat_q | sat_st;
			end
			ST_FIN: begin
				sat_q <= sat_q;
			end
			default: begin
				sat_q <= sat_q;
			end
		endcase
	end

	assign busy                 = (state_q != ST_IDLE);
	assign res_valid            = (state_q == ST_FIN);
	assign res_slope            = slope_q;
	assign res_icpt             = icpt_q;
	assign res_count            = n_q;
	assign res_flags.degenerate = deg_q;
	assign res_flags.saturated  = sat_q;

endmodule

// File: hw/rtl/least_squares_line_fit_unit.sv
`timescale 1ns / 1ps
// Least-squares line fit: points stream in at one beat per cycle while in_ready is
// high; the beat that closes a set starts the fit and drops in_ready until the one
// shared adder has stepped every product and quotient bit (a degenerate set stops
// once the denominator is known) and the result has moved into the output register,
// which it waits for while that register is full. The result then waits in the output
// register while new points are taken. Reset (arst_n low) clears the sums, the
// sequencer and out_valid.
module least_squares_line_fit_unit import lsf_pkg::*; #(
	parameter int MAX_POINTS  = LSF_MAX_POINTS,
	parameter int SAMPLE_BITS = LSF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_BITS-1:0]         x_sample,
	input  logic signed [SAMPLE_BITS-1:0]         y_sample,
	input  logic                                  last_point,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [LSF_OUT_W-1:0]           slope,
	output logic signed [LSF_OUT_W-1:0]           intercept,
	output logic                                  degenerate,
	output logic                                  saturated,
	output logic [$clog2(MAX_POINTS+1)-1:0]       point_count
);

	localparam int CW = $clog2(MAX_POINTS+1);
	localparam int SW = SAMPLE_BITS + CW;
	localparam int QW = 2*SAMPLE_BITS + CW;

	logic                 take, fit, busy, res_valid, res_take;
	logic [CW-1:0]        n_nx, res_count;
	logic signed [SW-1:0] sx_nx, sy_nx;
	logic signed [QW-1:0] sxx_nx, sxy_nx;
	logic [LSF_OUT_W-1:0] res_slope, res_icpt;
	lsf_flags_t           res_flags;

	logic                 out_valid_q;
	logic [LSF_OUT_W-1:0] slope_q, icpt_q;
	logic [CW-1:0]        count_q;
	lsf_flags_t           flags_q;

	// points are taken whenever the engine is free; the result register is separate
	assign in_ready = !busy;
	assign take     = in_valid && in_ready;

	lsf_accum #(
		.MAX_POINTS  (MAX_POINTS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.x_sample   (x_sample),
		.y_sample   (y_sample),
		.last_point (last_point),
		.fit        (fit),
		.n_nx       (n_nx),
		.sx_nx      (sx_nx),
		.sy_nx      (sy_nx),
		.sxx_nx     (sxx_nx),
		.sxy_nx     (sxy_nx)
	);

	lsf_engine #(
		.MAX_POINTS  (MAX_POINTS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (fit),
		.n_in      (n_nx),
		.sx_in     (sx_nx),
		.sy_in     (sy_nx),
		.sxx_in    (sxx_nx),
		.sxy_in    (sxy_nx),
		.res_take  (res_take),
		.busy      (busy),
		.res_valid (res_valid),
		.res_slope (res_slope),
		.res_icpt  (res_icpt),
		.res_count (res_count),
		.res_flags (res_flags)
	);

	// the engine hands over its result when the output register is empty or draining
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			slope_q <= res_slope;
			icpt_q  <= res_icpt;
			count_q <= res_count;
			flags_q <= res_flags;
		end
	end

	assign out_valid   = out_valid_q;
	assign slope       = slope_q;
	assign intercept   = icpt_q;
	assign point_count = count_q;
	assign degenerate  = flags_q.degenerate;
	assign saturated   = flags_q.saturated;

endmodule

// File: hw/rtl/lsf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the line fit unit, bound to the top level.
// Depends on lsf_pkg.
module lsf_checker import lsf_pkg::*; #(
	parameter int MAX_POINTS  = LSF_MAX_POINTS,
	parameter int SAMPLE_BITS = LSF_SAMPLE_BITS
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            last_point,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [LSF_OUT_W-1:0]            slope,
	input logic [LSF_OUT_W-1:0]            intercept,
	input logic                            degenerate,
	input logic                            saturated,
	input logic [$clog2(MAX_POINTS+1)-1:0] point_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slope) && $stable(intercept))
		else $error("result beat changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> slope == '0 && intercept == '0 && !saturated)
		else $error("degenerate fit with nonzero result");

	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_count != '0)
		else $error("result with zero point count");

	a_fit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_point |=> !in_ready)
		else $error("point taken while fit starts");

endmodule

bind least_squares_line_fit_unit lsf_checker #(
	.MAX_POINTS  (MAX_POINTS),
	.SAMPLE_BITS (SAMPLE_BITS)
) u_lsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.last_point  (last_point),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.slope       (slope),
	.intercept   (intercept),
	.degenerate  (degenerate),
	.saturated   (saturated),
	.point_count (point_count)
);

// File: bench/tb_least_squares_line_fit_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the least-squares line fit unit: streams point sets,
// predicts each fit exactly with wide integer math and checks every result beat.
// Depends on lsf_pkg and least_squares_line_fit_unit only.
module tb_least_squares_line_fit_unit;
	import lsf_pkg::*;

	localparam int SW        = LSF_SAMPLE_BITS;
	localparam int CNT_W     = $clog2(LSF_MAX_POINTS + 1);
	localparam int STALL_MAX = 20000;

	typedef struct {
		logic [LSF_OUT_W-1:0] slope;
		logic [LSF_OUT_W-1:0] intercept;
		logic                 degenerate;
		logic                 saturated;
		logic [CNT_W-1:0]     point_count;
	} line_fit_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic signed [SW-1:0]        x_sample;
	logic signed [SW-1:0]        y_sample;
	logic                        last_point;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [LSF_OUT_W-1:0] slope;
	logic signed [LSF_OUT_W-1:0] intercept;
	logic                        degenerate;
	logic                        saturated;
	logic [CNT_W-1:0]            point_count;

	least_squares_line_fit_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_sample(x_sample), .y_sample(y_sample), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.slope(slope), .intercept(intercept), .degenerate(degenerate),
		.saturated(saturated), .point_count(point_count)
	);

	// running sums of the open set, mirrored from the accepted beats
	int unsigned pts_in_set;
	longint      acc_x, acc_y, acc_xx, acc_xy;

	line_fit_t pending_fits[$];
	int        mismatches;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        recv_hold;
	int        stall_cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Round |num|*2^16/d to nearest, ties away from zero, clamp to 48 bits.
	function automatic logic [LSF_OUT_W-1:0] fixed_quotient(
		input logic signed [159:0] num, input logic [159:0] d, inout logic sat);
		logic          neg;
		logic [159:0]  mag, q, r, lim;
		neg = num < 0;
		mag = neg ? -num : num;
		mag = mag << LSF_FRAC;
		q = mag / d;
		r = mag % d;
		if (r >= d - r)
			q = q + 1;
		lim = (160'd1 << (LSF_OUT_W - 1)) - 1 + neg;
		if (q > lim) begin
			sat = 1'b1;
			q = lim;
		end
		return neg ? -q[LSF_OUT_W-1:0] : q[LSF_OUT_W-1:0];
	endfunction

	function automatic line_fit_t solve_line(input int unsigned n, input longint sx,
		input longint sy, input longint sxx, input longint sxy);
		line_fit_t        f;
		logic signed [159:0] wn, wsx, wsy, wsxx, wsxy, den, nb, na;
		logic                sat;
		wn = n; wsx = sx; wsy = sy; wsxx = sxx; wsxy = sxy;
		sat = 1'b0;
		f.point_count = n[CNT_W-1:0];
		den = wn * wsxx - wsx * wsx;
		if (den <= 0) begin
			f.slope = '0;
			f.intercept = '0;
			f.degenerate = 1'b1;
			f.saturated = 1'b0;
		end else begin
			nb = wn * wsxy - wsx * wsy;
			na = wsxx * wsy - wsx * wsxy;
			f.slope = fixed_quotient(nb, den, sat);
			f.intercept = fixed_quotient(na, den, sat);
			f.degenerate = 1'b0;
			f.saturated = sat;
		end
		return f;
	endfunction

	// Offer one point; idle first at random, then hold the beat until taken.
	task automatic send_point(input logic signed [SW-1:0] x, input logic signed [SW-1:0] y,
		input logic last);
		longint lx, ly;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		x_sample = x;
		y_sample = y;
		last_point = last;
		do @(posedge clk); while (!in_ready);
		// beat taken: advance the sums and close the set when due
		lx = x;
		ly = y;
		pts_in_set++;
		acc_x += lx;
		acc_y += ly;
		acc_xx += lx * lx;
		acc_xy += lx * ly;
		if (last || pts_in_set >= LSF_MAX_POINTS) begin
			pending_fits.push_back(solve_line(pts_in_set, acc_x, acc_y, acc_xx, acc_xy));
			pts_in_set = 0;
			acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
		end
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		wait (pending_fits.size() == 0);
		repeat (400) @(negedge clk);
	endtask

	// Receiver: stall at random, or hold off entirely while recv_hold runs.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_MAX) begin
				$display("timeout: no beat for %0d cycles", STALL_MAX);
				$display("** least_squares_line_fit_unit: FAILED **");
				$finish;
			end
		end
		if (arst_n && out_valid && out_ready) begin
			line_fit_t e;
			if (pending_fits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with no fit pending", $realtime);
			end else begin
				e = pending_fits.pop_front();
				if (slope !== e.slope || intercept !== e.intercept
					|| degenerate !== e.degenerate || saturated !== e.saturated
					|| point_count !== e.point_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: fit mismatch exp b=%0d a=%0d deg=%b sat=%b n=%0d got b=%0d a=%0d deg=%b sat=%b n=%0d",
							$realtime, $signed(e.slope), $signed(e.intercept), e.degenerate,
							e.saturated, e.point_count, slope, intercept, degenerate,
							saturated, point_count);
				end
			end
		end
	end

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// single point: degenerate
		send_point(-16'sd32768, -16'sd32768, 1'b1);
		// two points at opposite extremes
		send_point(-16'sd32768, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b1);
		// all x equal: degenerate
		send_point(16'sd32767, 16'sd5, 1'b0);
		send_point(16'sd32767, -16'sd9, 1'b0);
		send_point(16'sd32767, 16'sd0, 1'b1);
		// tight x far from origin with wild y: large intercept, may clamp
		send_point(16'sd32767, 16'sd32767, 1'b0);
		send_point(16'sd32766, -16'sd32768, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b0);
		send_point(16'sd32766, 16'sd32767, 1'b0);
		send_point(16'sd32766, 16'sd32767, 1'b1);
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point(-16'sd32767, 16'sd32767, 1'b0);
		send_point(-16'sd32767, 16'sd32767, 1'b1);
		// zeros and a plain line
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd3, 1'b0);
		send_point(16'sd2, 16'sd6, 1'b1);
		drop_valid();
		drain();
	endtask

	// Full-size set with no last flag: the point limit closes it; one marked point follows as a set of its own.
	task automatic test_point_limit();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < LSF_MAX_POINTS; i++)
			send_point(SW'($urandom), SW'($urandom), 1'b0);
		send_point(16'sd7, 16'sd7, 1'b1);
		drop_valid();
		drain();
	endtask

	task automatic send_random_set(output int len_out);
		int                   len, mode;
		logic signed [SW-1:0] base, x;
		len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
		mode = $urandom_range(3);
		base = SW'($urandom);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: x = SW'($urandom);
				1: x = $signed(16'($urandom_range(64))) - 16'sd32;
				2: x = (base > 16'sd32760) ? base - SW'($urandom_range(1))
					: base + SW'($urandom_range(1));
				default: x = base;
			endcase
			send_point(x, SW'($urandom), (i == len - 1));
		end
		len_out = len;
	endtask

	task automatic test_random(input int snd_pct, input int rcv_pct, input int points);
		int sent, len;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < points) begin
			send_random_set(len);
			sent += len;
		end
		drop_valid();
		drain();
	endtask

	// Hold the receiver off while short sets keep coming, so input stalls.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 1500;
		for (int i = 0; i < 30; i++)
			send_point(SW'($urandom), SW'($urandom), (i % 3 == 2));
		drop_valid();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_sample = '0;
		y_sample = '0;
		last_point = 1'b0;
		out_ready = 1'b0;
		recv_hold = 0;
		mismatches = 0;
		stall_cycles = 0;
		pts_in_set = 0;
		acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(28, 48, 150);
		test_random(48, 28, 150);
		test_random(0, 0, 150);
		test_backpressure();
		test_point_limit();

		if (mismatches == 0 && pending_fits.size() == 0)
			$display("** least_squares_line_fit_unit: PASSED **");
		else
			$display("** least_squares_line_fit_unit: FAILED **");
		$finish;
	end

endmodule
